// ===== rtl/ksdm_pkg.sv =====
// ----------------------------------------------------------------------------
// ksdm_pkg - shared types and codes of the k-slot mutex node
// Message kinds, local actions, register indexes and the result word layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ksdm_pkg;

  // default peer table depth
  localparam int MAX_NODES_DEF = 16;

  // local actions
  localparam logic [1:0] ACT_MSG    = 2'd0;
  localparam logic [1:0] ACT_WORK   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // received message kinds
  localparam logic [1:0] KIND_SLOT_REQ   = 2'd0;
  localparam logic [1:0] KIND_SLOT_AGREE = 2'd1;
  localparam logic [1:0] KIND_WIN_REQ    = 2'd2;
  localparam logic [1:0] KIND_OTHER      = 2'd3;

  // sent message kinds
  localparam logic [1:0] OUT_SLOT_REQ   = 2'd0;
  localparam logic [1:0] OUT_SLOT_AGREE = 2'd1;
  localparam logic [1:0] OUT_WIN_AGREE  = 2'd2;
  localparam logic [1:0] OUT_GRANT      = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
  localparam logic [1:0] CFG_SLOT_COUNT = 2'd2;

  // node phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_REQ  = 2'd1,
    PH_POOL = 2'd2
  } phase_t;

  // one result word, without the last flag
  typedef struct packed {
    logic [3:0]  dest;
    logic [1:0]  out_kind;
    logic [31:0] out_clock;
    logic [31:0] out_value;
    logic [7:0]  served_count;
  } result_t;

  // sequencer to output stage
  typedef struct packed {
    logic    emit;
    logic    flush;
    result_t data;
  } emit_ctl_t;

  // output stage to sequencer
  typedef struct packed {
    logic emit_ok;
    logic flush_ok;
  } emit_sts_t;

endpackage

// ===== rtl/ksdm_if.sv =====
// ----------------------------------------------------------------------------
// ksdm_if - channel interfaces of the k-slot mutex node
// Input item, result word and configuration write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ksdm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  msg_kind;
  logic [3:0]  sender;
  logic [31:0] sender_clock;
  logic [31:0] msg_value;
  logic [7:0]  work_count;
  modport source (output valid, action, msg_kind, sender, sender_clock, msg_value,
                  work_count, input ready);
  modport sink (input valid, action, msg_kind, sender, sender_clock, msg_value,
                work_count, output ready);
endinterface

interface ksdm_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  dest;
  logic [1:0]  out_kind;
  logic [31:0] out_clock;
  logic [31:0] out_value;
  logic [7:0]  served_count;
  logic        last;
  modport source (output valid, dest, out_kind, out_clock, out_value, served_count,
                  last, input ready);
  modport sink (input valid, dest, out_kind, out_clock, out_value, served_count,
                last, output ready);
endinterface

interface ksdm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ksdm_out_stage.sv =====
// ----------------------------------------------------------------------------
// ksdm_out_stage - result word look-ahead and output register
// Holds one word back until the next is known, so that last can be set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksdm_out_stage
  import ksdm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  emit_ctl_t        ctl,
  output emit_sts_t        sts,
  ksdm_out_if.source       res
);

  logic    hold_v;
  result_t hold;
  logic    out_v;
  result_t out_w;
  logic    out_last;
  logic    out_free;

  assign out_free     = !out_v || res.ready;
  assign sts.emit_ok  = !hold_v || out_free;
  assign sts.flush_ok = !hold_v || out_free;

  // held word moves on when a successor arrives or the step ends
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if (out_v && res.ready) out_v <= 1'b0;
      if (ctl.emit && sts.emit_ok) begin
        if (hold_v) begin
          out_w    <= hold;
          out_last <= 1'b0;
          out_v    <= 1'b1;
        end
        hold   <= ctl.data;
        hold_v <= 1'b1;
      end else if (ctl.flush && hold_v && out_free) begin
        out_w    <= hold;
        out_last <= 1'b1;
        out_v    <= 1'b1;
        hold_v   <= 1'b0;
      end
    end
  end

  assign res.valid        = out_v;
  assign res.dest         = out_w.dest;
  assign res.out_kind     = out_w.out_kind;
  assign res.out_clock    = out_w.out_clock;
  assign res.out_value    = out_w.out_value;
  assign res.served_count = out_w.served_count;
  assign res.last         = out_last;

endmodule

// ===== rtl/k_slot_distributed_mutex_node_top.sv =====
// ----------------------------------------------------------------------------
// k_slot_distributed_mutex_node_top - one node of a k-slot Lamport mutex
// Sequencer over the peer tables with a shared occupancy accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one peer message or local event per word (valid/ready).
//   result : messages to send and grant status, one per word; last marks
//            the final word of an item. Items with no result give no word.
//   cfg    : register writes (node_id, node_count, slot_count), always ready;
//            write only while no item is in flight.
// Flow: an item is taken only when the sequencer is idle. A step that sums
//   occupancy walks every peer-table entry into the shared accumulator, and
//   each sweep over the peer table (request broadcast, deferred agrees,
//   releases) steps the single peer-table index through every entry. A
//   release sends the deferred agrees, then the releases, and if work
//   remains re-requests with a new broadcast followed by the grant check.
// Reset: phase idle, clock zero, agree/occupant/defer flags clear, registers at defaults.
// Stall: one word is held back for the last flag plus one output register;
//   a stalled receiver freezes the sweep until a word slot frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module k_slot_distributed_mutex_node_top
  import ksdm_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ksdm_in_if.sink    item,
  ksdm_out_if.source result,
  ksdm_cfg_if.sink   cfg
);

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ACC_W = 32 + IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_NODES - 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DECODE  = 9'b000000010,
    S_MSG     = 9'b000000100,
    S_TRY     = 9'b000001000,
    S_SUM     = 9'b000010000,
    S_SUMDONE = 9'b000100000,
    S_REQS    = 9'b001000000,
    S_DEFS    = 9'b010000000,
    S_OCCS    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    PUR_GRANT = 2'd0,
    PUR_REL   = 2'd1,
    PUR_REQ   = 2'd2
  } purpose_t;

  state_t   state;
  logic     finishing;
  purpose_t purpose;
  logic     def_release;

  // configuration
  logic [3:0] node_id;
  logic [4:0] node_count;
  logic [7:0] slot_count;

  // latched item
  logic [1:0]  act;
  logic [1:0]  kind;
  logic [3:0]  snd;
  logic [31:0] t_in;
  logic [31:0] val;
  logic [7:0]  work;

  // node state
  phase_t      phase;
  logic [31:0] clock;
  logic [31:0] request_stamp;
  logic [7:0]  pending_units;
  logic [7:0]  held_units;
  logic [MAX_NODES-1:0] agreed;
  logic [MAX_NODES-1:0] occ_valid;
  logic [MAX_NODES-1:0] deferred;
  logic [31:0] occ_units [MAX_NODES];

  logic [IDX_W-1:0] idx;
  logic [ACC_W-1:0] acc;

  emit_ctl_t ctl;
  emit_sts_t sts;

  function automatic logic is_peer(input logic [3:0] i, input logic [3:0] nid,
                                   input logic [4:0] ncnt);
    return ({1'b0, i} < ncnt) && (i != nid) && (32'(i) < 32'(MAX_NODES));
  endfunction

  logic [3:0]       idx_id;
  logic [IDX_W-1:0] snd_i;
  logic [IDX_W-1:0] nid_i;
  logic [IDX_W-1:0] idx_step;
  logic             snd_peer;
  logic             idx_peer;
  logic             all_agreed;
  logic             occ_lt;
  logic [7:0]       free_u;
  logic [7:0]       served;
  logic [31:0]      clk_max;
  logic             stamp_defer;
  logic             step_ok;

  assign idx_id   = 4'(idx);
  assign snd_i    = snd[IDX_W-1:0];
  assign nid_i    = node_id[IDX_W-1:0];
  // sweep index wraps to zero after the last table entry
  assign idx_step = (idx == IDX_LAST) ? '0 : idx + 1'b1;
  assign snd_peer = is_peer(snd, node_id, node_count);
  assign idx_peer = is_peer(idx_id, node_id, node_count);
  assign occ_lt   = acc < ACC_W'(slot_count);
  assign free_u   = occ_lt ? (slot_count - acc[7:0]) : 8'd0;
  assign served   = (pending_units < free_u) ? pending_units : free_u;
  assign clk_max  = (clock > t_in) ? clock : t_in;
  assign stamp_defer = (request_stamp < t_in) ||
                       ((request_stamp == t_in) && (node_id < snd));

  // every peer has agreed (non-peers count as agreed)
  always_comb begin
    all_agreed = 1'b1;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (is_peer(4'(i), node_id, node_count) && !agreed[i]) all_agreed = 1'b0;
    end
  end

  // result word offered in the current state
  always_comb begin
    ctl.emit  = 1'b0;
    ctl.flush = finishing;
    ctl.data  = '0;
    case (state)
      S_MSG: begin
        if (snd_peer && kind == KIND_WIN_REQ) begin
          ctl.emit = 1'b1;
          ctl.data = '{snd, OUT_WIN_AGREE,
                       (phase != PH_IDLE) ? clock + 32'd1 : clock, val, 8'd0};
        end else if (snd_peer && kind == KIND_SLOT_REQ && phase == PH_IDLE) begin
          ctl.emit = 1'b1;
          ctl.data = '{snd, OUT_SLOT_AGREE, clock, 32'd0, 8'd0};
        end
      end
      S_SUMDONE: begin
        if (purpose == PUR_GRANT) begin
          ctl.emit = 1'b1;
          ctl.data = '{node_id, OUT_GRANT, clock, {24'd0, pending_units - served},
                       served};
        end else if (purpose == PUR_REQ && occ_lt) begin
          ctl.emit = 1'b1;
          ctl.data = '{snd, OUT_SLOT_AGREE, clock + 32'd1, 32'd0, 8'd0};
        end
      end
      S_REQS: begin
        if (idx_peer) begin
          ctl.emit = 1'b1;
          ctl.data = '{idx_id, OUT_SLOT_REQ, request_stamp, {24'd0, pending_units},
                       8'd0};
        end
      end
      S_DEFS: begin
        if (idx_peer && deferred[idx]) begin
          ctl.emit = 1'b1;
          ctl.data = def_release ?
                     '{idx_id, OUT_SLOT_AGREE, clock, {24'd0, held_units}, 8'd0} :
                     '{idx_id, OUT_SLOT_AGREE, clock + 32'd1, 32'd0, 8'd0};
        end
      end
      S_OCCS: begin
        if (idx_peer && occ_valid[idx]) begin
          ctl.emit = 1'b1;
          ctl.data = '{idx_id, OUT_SLOT_AGREE, clock, {24'd0, held_units}, 8'd0};
        end
      end
      default: ;
    endcase
  end

  assign step_ok    = !ctl.emit || sts.emit_ok;
  assign item.ready = (state == S_IDLE) && !finishing;
  assign cfg.ready  = 1'b1;

  ksdm_out_stage u_out (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts),
    .res (result)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id    <= 4'd0;
      node_count <= 5'd2;
      slot_count <= 8'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_NODE_ID:    node_id    <= cfg.data[3:0];
        CFG_NODE_COUNT: node_count <= cfg.data[4:0];
        CFG_SLOT_COUNT: slot_count <= cfg.data;
        default: ;
      endcase
    end
  end

  // occupant unit table, written by message handling and grant
  always_ff @(posedge clk) begin
    if (state == S_MSG && snd_peer && kind == KIND_SLOT_REQ &&
        (phase == PH_IDLE || (phase == PH_REQ && !stamp_defer)))
      occ_units[snd_i] <= val;
    else if (state == S_SUMDONE && purpose == PUR_REQ && occ_lt)
      occ_units[snd_i] <= val;
    else if (state == S_SUMDONE && purpose == PUR_GRANT)
      occ_units[nid_i] <= {24'd0, pending_units};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      finishing     <= 1'b0;
      phase         <= PH_IDLE;
      clock         <= 32'd0;
      request_stamp <= 32'd0;
      pending_units <= 8'd0;
      held_units    <= 8'd0;
      agreed        <= '0;
      occ_valid     <= '0;
      deferred      <= '0;
      idx           <= '0;
      acc           <= '0;
      purpose       <= PUR_GRANT;
      def_release   <= 1'b0;
    end else if (finishing) begin
      if (sts.flush_ok) finishing <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            act   <= item.action;
            kind  <= item.msg_kind;
            snd   <= item.sender;
            t_in  <= item.sender_clock;
            val   <= item.msg_value;
            work  <= item.work_count;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          idx   <= '0;
          state <= S_IDLE;
          if (act == ACT_MSG) begin
            clock <= clk_max + 32'd1;
            state <= S_MSG;
          end else if (act == ACT_WORK && phase == PH_IDLE && work != 8'd0) begin
            pending_units <= work;
            clock         <= clock + 32'd1;
            request_stamp <= clock + 32'd1;
            agreed        <= '0;
            phase         <= PH_REQ;
            state         <= S_REQS;
          end else if (act == ACT_FINISH && phase == PH_POOL) begin
            clock       <= clock + 32'd1;
            def_release <= 1'b1;
            state       <= S_DEFS;
          end else begin
            finishing <= 1'b1;
          end
        end
        S_MSG: begin
          if (step_ok) begin
            state     <= S_IDLE;
            finishing <= 1'b1;
            acc       <= '0;
            idx       <= '0;
            if (snd_peer) begin
              case (kind)
                KIND_WIN_REQ: clock <= clock + 32'd1;
                KIND_SLOT_AGREE: begin
                  if (val != 32'd0) occ_valid[snd_i] <= 1'b0;
                  if (phase == PH_REQ) begin
                    agreed[snd_i] <= 1'b1;
                    state         <= S_TRY;
                    finishing     <= 1'b0;
                  end else if (phase == PH_POOL && val != 32'd0) begin
                    purpose   <= PUR_REL;
                    state     <= S_SUM;
                    finishing <= 1'b0;
                  end
                end
                KIND_SLOT_REQ: begin
                  if (phase == PH_IDLE) begin
                    occ_valid[snd_i] <= 1'b1;
                    clock            <= clock + 32'd1;
                  end else if (phase == PH_REQ) begin
                    if (stamp_defer) begin
                      deferred[snd_i] <= 1'b1;
                      agreed[snd_i]   <= 1'b1;
                      state           <= S_TRY;
                      finishing       <= 1'b0;
                    end else begin
                      occ_valid[snd_i] <= 1'b1;
                    end
                  end else if (phase == PH_POOL) begin
                    purpose   <= PUR_REQ;
                    state     <= S_SUM;
                    finishing <= 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_TRY: begin
          acc <= '0;
          idx <= '0;
          if (all_agreed) begin
            purpose <= PUR_GRANT;
            state   <= S_SUM;
          end else begin
            state     <= S_IDLE;
            finishing <= 1'b1;
          end
        end
        S_SUM: begin
          if (occ_valid[idx]) acc <= acc + ACC_W'(occ_units[idx]);
          idx <= idx_step;
          if (idx == IDX_LAST) state <= S_SUMDONE;
        end
        S_SUMDONE: begin
          if (step_ok) begin
            idx       <= '0;
            state     <= S_IDLE;
            finishing <= 1'b1;
            case (purpose)
              PUR_GRANT: begin
                held_units       <= pending_units;
                pending_units    <= pending_units - served;
                occ_valid[nid_i] <= 1'b1;
                phase            <= PH_POOL;
              end
              PUR_REL: begin
                if (occ_lt) begin
                  def_release <= 1'b0;
                  state       <= S_DEFS;
                  finishing   <= 1'b0;
                end
              end
              default: begin
                if (occ_lt) begin
                  occ_valid[snd_i] <= 1'b1;
                  clock            <= clock + 32'd1;
                end else begin
                  deferred[snd_i] <= 1'b1;
                end
              end
            endcase
          end
        end
        S_REQS: begin
          if (step_ok) begin
            idx <= idx_step;
            if (idx == IDX_LAST) state <= S_TRY;
          end
        end
        S_DEFS: begin
          if (step_ok) begin
            if (ctl.emit && !def_release) clock <= clock + 32'd1;
            idx <= idx_step;
            if (idx == IDX_LAST) begin
              deferred <= '0;
              if (def_release) begin
                state <= S_OCCS;
              end else begin
                state     <= S_IDLE;
                finishing <= 1'b1;
              end
            end
          end
        end
        S_OCCS: begin
          if (step_ok) begin
            idx <= idx_step;
            if (idx == IDX_LAST) begin
              occ_valid[nid_i] <= 1'b0;
              if (pending_units != 8'd0) begin
                clock         <= clock + 32'd1;
                request_stamp <= clock + 32'd1;
                agreed        <= '0;
                phase         <= PH_REQ;
                state         <= S_REQS;
              end else begin
                phase     <= PH_IDLE;
                state     <= S_IDLE;
                finishing <= 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item taken while sequencer busy");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !finishing && phase == PH_IDLE) |-> (pending_units == 8'd0))
    else $error("idle phase with pending work");

  a_grant_enters_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUMDONE && purpose == PUR_GRANT && step_ok) |=> (phase == PH_POOL))
    else $error("grant did not enter the pool");

endmodule
